@@ design/ncd_pkg.sv @@
package ncd_pkg;

  // Field widths fixed by the transaction format.
  localparam int ADDR_FIELD_W = 48;
  localparam int COUNT_W      = 12;
  localparam int THRESH_W     = 8;

  // Slave-side tdata: node_address, commit, zero fill to whole bytes.
  localparam int IN_TDATA_W  = 56;
  // Master-side tdata: significant, new_count, common_count, appeared_count,
  // overflow, zero fill to whole bytes.
  localparam int OUT_TDATA_W = 40;

  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd64;

  localparam int DEFAULT_TABLE_DEPTH  = 64;
  localparam int DEFAULT_ADDRESS_BITS = 48;

  // Control from the top level to the table search unit.
  typedef struct packed {
    logic start;   // begin a search for the latched key
    logic wr_en;   // store the key in the inactive bank
    logic bank;    // bank that holds the old table
  } scan_req_t;

  // Status from the table search unit.
  typedef struct packed {
    logic done;    // search finished this cycle
    logic hit;     // key found in the old table
  } scan_rsp_t;

endpackage

@@ design/neighbour_change_detector_unit.sv @@
// Neighbour change detector. A new neighbour list arrives one node address per
// transaction (tlast low); a transaction with tlast high ends the list and
// returns one result with the new, common and appeared counts, the overflow
// flag and the significant-change decision, appeared*256 > threshold*old_count.
// With commit set in that transaction the new list becomes the old table by
// swapping banks of a single table memory. An address transaction searches the
// old table and ends early when a match is found: the old table is read from
// the memory port one entry per cycle and each entry is compared in the cycle
// after its read. The next list may start while the result waits in the output
// register.
module neighbour_change_detector_unit
  import ncd_pkg::*;
#(
  parameter int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH,
  parameter int ADDRESS_BITS = DEFAULT_ADDRESS_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // Threshold register write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [THRESH_W-1:0]    cfg_data,
  // Input items.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // node_address[47:0], commit[48]
  input  logic                   s_axis_tlast,   // func: end of list
  // Results.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // significant[0], new_count[12:1],
                                                 // common_count[24:13],
                                                 // appeared_count[36:25], overflow[37]
);

  localparam int IdxW     = $clog2(TABLE_DEPTH);
  localparam int CntW     = $clog2(TABLE_DEPTH + 1);
  localparam int StoredW  = (ADDRESS_BITS < ADDR_FIELD_W) ? ADDRESS_BITS : ADDR_FIELD_W;
  localparam int ProdW    = THRESH_W + CntW;
  localparam int CmpW     = COUNT_W + THRESH_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                state;
  logic                state_next;
  logic [THRESH_W-1:0] threshold;
  logic                active_bank;
  logic [CntW-1:0]     old_count;
  logic [COUNT_W-1:0]  pending_count;
  logic [COUNT_W-1:0]  matched_count;
  logic                overflow_flag;

  logic                in_accept;
  logic                entry_accept;
  logic                eval_accept;
  logic                commit;
  logic                room;
  logic [COUNT_W-1:0]  appeared;
  logic [ProdW-1:0]    limit;
  logic                significant;
  scan_req_t           req;
  scan_rsp_t           rsp;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE) &&
                         (!s_axis_tlast || !m_axis_tvalid || m_axis_tready);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign entry_accept  = in_accept && !s_axis_tlast;
  assign eval_accept   = in_accept && s_axis_tlast;
  assign commit        = s_axis_tdata[ADDR_FIELD_W];
  assign room          = pending_count < COUNT_W'(TABLE_DEPTH);

  assign req.start = entry_accept;
  assign req.wr_en = entry_accept && room;
  assign req.bank  = active_bank;

  ncd_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .STORED_W    (StoredW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .old_count (old_count),
    .key       (s_axis_tdata[StoredW-1:0]),
    .wr_idx    (pending_count[IdxW-1:0]),
    .rsp       (rsp)
  );

  // Change decision by cross-multiplying instead of dividing by old_count.
  assign appeared    = pending_count - matched_count;
  assign limit       = ProdW'(threshold) * ProdW'(old_count);
  assign significant = (appeared != '0) &&
                       ((old_count == '0) || ({appeared, 8'h00} > CmpW'(limit)));

  // Busy while the old table is being searched.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (entry_accept) state_next = ST_SCAN;
      ST_SCAN: if (rsp.done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // List counters, overflow flag and bank state.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank   <= 1'b0;
      old_count     <= '0;
      pending_count <= '0;
      matched_count <= '0;
      overflow_flag <= 1'b0;
    end else if (eval_accept) begin
      if (commit) begin
        active_bank <= ~active_bank;
        old_count   <= room ? CntW'(pending_count) : CntW'(TABLE_DEPTH);
      end
      pending_count <= '0;
      matched_count <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (entry_accept) begin
        if (!room) overflow_flag <= 1'b1;
        if (pending_count != COUNT_MAX) pending_count <= pending_count + 1'b1;
      end
      if ((state == ST_SCAN) && rsp.done && rsp.hit && (matched_count != COUNT_MAX)) begin
        matched_count <= matched_count + 1'b1;
      end
    end
  end

  // Output register; a result waits here while new entries are taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (eval_accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_accept) begin
      m_axis_tdata <= {2'b00, overflow_flag, appeared, matched_count, pending_count,
                       significant};
    end
  end

endmodule

@@ design/ncd_scan.sv @@
module ncd_scan
  import ncd_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int STORED_W    = DEFAULT_ADDRESS_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  scan_req_t                              req,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]       old_count,
  input  logic [STORED_W-1:0]                    key,
  input  logic [$clog2(TABLE_DEPTH)-1:0]         wr_idx,
  output scan_rsp_t                              rsp
);

  localparam int IdxW     = $clog2(TABLE_DEPTH);
  localparam int CntW     = $clog2(TABLE_DEPTH + 1);
  localparam int MemDepth = 2 * (1 << IdxW);

  // Both banks share one memory; the bank select is the top address bit.
  logic [STORED_W-1:0] mem [0:MemDepth-1];
  logic [STORED_W-1:0] mem_q;

  logic                busy;
  logic [CntW-1:0]     issue_idx;
  logic [STORED_W-1:0] key_reg;
  logic                rd_vld;
  logic                rd_last;
  logic                issue;
  logic                key_eq;
  logic                finish;

  assign issue  = busy && (issue_idx != old_count);
  assign key_eq = (mem_q == key_reg);
  assign finish = busy && ((old_count == '0) || (rd_vld && (key_eq || rd_last)));

  assign rsp.done = finish;
  assign rsp.hit  = rd_vld && key_eq;

  // New list goes to the inactive bank; the old table is read from the active one.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[{~req.bank, wr_idx}] <= key;
    end
    mem_q <= mem[{req.bank, issue_idx[IdxW-1:0]}];
  end

  // Search sequencer: one read issued per cycle, each compared in the cycle after its issue.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rd_vld    <= 1'b0;
      rd_last   <= 1'b0;
      issue_idx <= '0;
    end else if (req.start) begin
      busy      <= 1'b1;
      rd_vld    <= 1'b0;
      issue_idx <= '0;
    end else if (finish) begin
      busy   <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld  <= issue;
      rd_last <= (issue_idx + 1'b1) == old_count;
      if (issue) begin
        issue_idx <= issue_idx + 1'b1;
      end
    end
  end

  // Key is held for the whole search.
  always_ff @(posedge clk) begin
    if (req.start) begin
      key_reg <= key;
    end
  end

endmodule

@@ design/ncd_checker.sv @@
module ncd_checker
  import ncd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A fresh result follows an end-of-list transaction.
  a_cause: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("result without end of list");

  // Common entries never exceed the list length, and appeared is the rest.
  a_counts: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[24:13] <= m_axis_tdata[12:1]) &&
      (m_axis_tdata[36:25] == m_axis_tdata[12:1] - m_axis_tdata[24:13]))
    else $error("inconsistent counts");

  // No new entries means no significant change.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[36:25] == '0) |-> !m_axis_tdata[0])
    else $error("significant without appeared entries");

endmodule

bind neighbour_change_detector_unit ncd_checker u_ncd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/sv/tb_neighbour_change_detector_unit.sv @@
`timescale 1ns / 100ps

module tb_neighbour_change_detector_unit;
  import ncd_pkg::*;

  localparam int TBL_DEPTH    = DEFAULT_TABLE_DEPTH;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int SETTLE       = TBL_DEPTH + 16;
  localparam int COUNT_LIMIT  = int'(COUNT_MAX);

  // One evaluation report, packed as the result tdata, lowest field last.
  typedef struct packed {
    logic               overflow;
    logic [COUNT_W-1:0] appeared_count;
    logic [COUNT_W-1:0] common_count;
    logic [COUNT_W-1:0] new_count;
    logic               significant;
  } change_report_t;

  // One directed transaction with an optional hand-written report.
  typedef struct packed {
    logic                    is_end;
    logic [ADDR_FIELD_W-1:0] addr;
    logic                    commit;
    logic                    typed;
    change_report_t          report;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [21] = '{
    // Empty list right after reset.
    '{1'b1, 48'h0, 1'b0, 1'b1, '{1'b0, 12'd0, 12'd0, 12'd0, 1'b0}},
    // Address extremes against an empty old table, then committed.
    '{1'b0, 48'h0, 1'b0, 1'b0, '0},
    '{1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{1'b1, 48'h0, 1'b1, 1'b1, '{1'b0, 12'd2, 12'd0, 12'd2, 1'b1}},
    // Every entry found, one of them twice.
    '{1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{1'b0, 48'h0, 1'b0, 1'b0, '0},
    '{1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{1'b1, 48'h0, 1'b0, 1'b1, '{1'b0, 12'd0, 12'd3, 12'd3, 1'b0}},
    // One new and one known entry, table kept.
    '{1'b0, 48'h1234_5678_9ABC, 1'b0, 1'b0, '0},
    '{1'b0, 48'h0, 1'b0, 1'b0, '0},
    '{1'b1, 48'h0, 1'b0, 1'b1, '{1'b0, 12'd1, 12'd1, 12'd2, 1'b1}},
    // Top address bit alone, committed as a one-entry table.
    '{1'b0, 48'h8000_0000_0000, 1'b0, 1'b0, '0},
    '{1'b1, 48'h0, 1'b1, 1'b1, '{1'b0, 12'd1, 12'd0, 12'd1, 1'b1}},
    '{1'b0, 48'h8000_0000_0000, 1'b0, 1'b0, '0},
    '{1'b1, 48'h0, 1'b0, 1'b1, '{1'b0, 12'd0, 12'd1, 12'd1, 1'b0}},
    // Alternating bit patterns.
    '{1'b0, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, '0},
    '{1'b0, 48'h5555_5555_5555, 1'b0, 1'b0, '0},
    '{1'b1, 48'h0, 1'b1, 1'b1, '{1'b0, 12'd2, 12'd0, 12'd2, 1'b1}},
    // Committing an empty list empties the old table.
    '{1'b1, 48'h0, 1'b1, 1'b1, '{1'b0, 12'd0, 12'd0, 12'd0, 1'b0}},
    '{1'b0, 48'h0000_0000_0001, 1'b0, 1'b0, '0},
    '{1'b1, 48'h0, 1'b0, 1'b1, '{1'b0, 12'd1, 12'd0, 12'd1, 1'b1}}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [THRESH_W-1:0]    cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // node_address[47:0], commit[48]
  logic                   s_axis_tlast = 1'b0; // func: end of list
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // significant[0], new_count[12:1],
                                               // common_count[24:13],
                                               // appeared_count[36:25], overflow[37]

  // Shadow copy of the neighbour tables, counters and threshold.
  logic [ADDR_FIELD_W-1:0] bank_mem [2][TBL_DEPTH];
  bit                      active_sel = 1'b0;
  int                      old_entries = 0;
  int                      list_len = 0;
  int                      list_hits = 0;
  bit                      list_overflow = 1'b0;
  logic [THRESH_W-1:0]     threshold_q = THRESH_RESET;

  change_report_t expected_reports [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  holds_requested = 0;
  int  holds_served = 0;
  int  stall_left = 0;
  int  items_sent = 0;
  int  lists_sent = 0;
  int  reports_checked = 0;
  int  significant_seen = 0;
  int  overflow_seen = 0;
  int  mismatches = 0;
  int  cycle_count = 0;

  neighbour_change_detector_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (holds_served != holds_requested) begin
      holds_served  <= holds_requested;
      stall_left    <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
    end
  endtask

  // Check each report transaction against the oldest expected report.
  always @(posedge clk) begin
    change_report_t got;
    change_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(change_report_t)-1:0];
      if (expected_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected report, expected none actual %h", $realtime, got);
      end else begin
        want = expected_reports[0];
        expected_reports.delete(0);
        reports_checked++;
        if (got.significant) significant_seen++;
        if (got.overflow) overflow_seen++;
        compare_field("significant", want.significant, got.significant);
        compare_field("new_count", want.new_count, got.new_count);
        compare_field("common_count", want.common_count, got.common_count);
        compare_field("appeared_count", want.appeared_count, got.appeared_count);
        compare_field("overflow", want.overflow, got.overflow);
      end
    end
  end

  // Offer one transaction, wait for it to be taken, then update the shadow state.
  task automatic send_item(input bit is_end, input logic [ADDR_FIELD_W-1:0] addr,
                           input bit commit, input bit typed, input change_report_t given);
    bit             hit;
    int             appeared;
    change_report_t rep;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, commit, addr};
    s_axis_tlast  <= is_end;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (!is_end) begin
      // New entry: look it up in the old table and store it in the other bank.
      hit = 1'b0;
      for (int i = 0; i < old_entries; i++)
        if (bank_mem[active_sel][i] == addr) hit = 1'b1;
      if (hit && list_hits < COUNT_LIMIT) list_hits++;
      if (list_len < TBL_DEPTH) bank_mem[!active_sel][list_len] = addr;
      else list_overflow = 1'b1;
      if (list_len < COUNT_LIMIT) list_len++;
    end else begin
      // End of list: decide by cross-multiplying against the threshold.
      appeared = list_len - list_hits;
      if (appeared == 0) rep.significant = 1'b0;
      else if (old_entries == 0) rep.significant = 1'b1;
      else rep.significant = (appeared * 256 > int'(threshold_q) * old_entries);
      rep.new_count      = list_len[COUNT_W-1:0];
      rep.common_count   = list_hits[COUNT_W-1:0];
      rep.appeared_count = appeared[COUNT_W-1:0];
      rep.overflow       = list_overflow;
      if (typed) rep = given;
      expected_reports.insert(expected_reports.size(), rep);
      if (commit) begin
        active_sel  = !active_sel;
        old_entries = (list_len < TBL_DEPTH) ? list_len : TBL_DEPTH;
      end
      list_len      = 0;
      list_hits     = 0;
      list_overflow = 1'b0;
      lists_sent++;
    end
  endtask

  // Sender stops offering until every expected report has arrived.
  task automatic wait_reports_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
  endtask

  // The threshold changes only once the block has gone quiet.
  task automatic write_threshold(input logic [THRESH_W-1:0] value);
    wait_reports_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    threshold_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly addresses already in the old table or in the list so far, so that
  // matches and duplicates are common.
  function automatic logic [ADDR_FIELD_W-1:0] pick_neighbour_address();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5 && old_entries != 0)
      return bank_mem[active_sel][$urandom_range(old_entries - 1)];
    if (sel < 7 && list_len != 0 && list_len <= TBL_DEPTH)
      return bank_mem[!active_sel][$urandom_range(list_len - 1)];
    if (sel == 8) return ($urandom_range(1) != 0) ? '1 : '0;
    if (sel == 9) return 48'h1 << $urandom_range(ADDR_FIELD_W - 1);
    return {16'($urandom()), $urandom()};
  endfunction

  // Whole lists with random content, lengths mostly short, a few around the
  // table depth so that overflow comes up.
  task automatic run_random_lists(input int item_goal);
    int goal;
    int len;
    int pick;
    goal = items_sent + item_goal;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 4) len = TBL_DEPTH + $urandom_range(0, 6);
      else if (pick < 10) len = 0;
      else len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
        send_item(1'b0, pick_neighbour_address(), 1'($urandom_range(1)), 1'b0, '0);
      send_item(1'b1, {16'($urandom()), $urandom()}, ($urandom_range(99) < 60),
                1'b0, '0);
      if ($urandom_range(7) == 0) wait_reports_drained();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed rows at the reset threshold; sender idles less than receiver.
    send_idle_pct = 30;
    recv_idle_pct = 52;
    foreach (DIRECTED_ROWS[r])
      send_item(DIRECTED_ROWS[r].is_end, DIRECTED_ROWS[r].addr, DIRECTED_ROWS[r].commit,
                DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].report);

    write_threshold(8'd255);
    run_random_lists(175);

    // Roles swapped, lowest threshold, and one long hold-off on the result
    // side while short lists keep coming.
    send_idle_pct = 52;
    recv_idle_pct = 30;
    write_threshold(8'd0);
    holds_requested++;
    repeat (8) begin
      if ($urandom_range(1) != 0)
        send_item(1'b0, pick_neighbour_address(), 1'b0, 1'b0, '0);
      send_item(1'b1, '0, 1'($urandom_range(1)), 1'b0, '0);
    end
    wait_reports_drained();
    run_random_lists(175);

    // No idling from here on.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_threshold(8'd128);
    run_random_lists(175);
    write_threshold(8'($urandom_range(1, 254)));
    run_random_lists(175);

    wait_reports_drained();
    repeat (SETTLE) @(negedge clk);
    if (expected_reports.size() != 0) begin
      mismatches += expected_reports.size();
      $display("%0t: %0d reports expected but never seen", $realtime,
               expected_reports.size());
    end

    $display("Sent %0d transactions in %0d neighbour lists; %0d reports checked.",
             items_sent, lists_sent, reports_checked);
    $display("Reports flagged significant: %0d, with table overflow: %0d.",
             significant_seen, overflow_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ neighbour_change_detector_unit.f @@
design/ncd_pkg.sv
design/ncd_scan.sv
design/neighbour_change_detector_unit.sv
design/ncd_checker.sv
tb/sv/tb_neighbour_change_detector_unit.sv
